### design/rcid_pkg.sv
// Shared types and constants of the ray-circle intersection distance block.
package rcid_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TOL   = 2'd3;

    localparam int SQ_N     = 63;
    localparam int DV_N     = 32;
    localparam int DIR_FRAC = 30;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        radius;
        logic [15:0]        on_surface_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [31:0] distance;
        logic        hit;
        logic        on_surface;
    } t_res;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] hm;
        logic        hneg;
        logic        cneg;
        logic        cpos;
        logic        dzero;
        logic        dneg;
        logic        on_surf;
    } t_ctx;

endpackage

### design/rcid_in_if.sv
// Request channel: point and direction with valid/ready handshake.
interface rcid_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;

    modport source (output valid, output pos_x, output pos_y, output dir_x, output dir_y,
                    input ready);
    modport sink (input valid, input pos_x, input pos_y, input dir_x, input dir_y,
                  output ready);
endinterface

### design/rcid_out_if.sv
// Result channel: distance, hit and on-surface flag with valid/ready handshake.
interface rcid_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;
    logic        hit;
    logic        on_surface;

    modport source (output valid, output distance, output hit, output on_surface,
                    input ready);
    modport sink (input valid, input distance, input hit, input on_surface,
                  output ready);
endinterface

### design/ray_circle_intersection_distance.sv
// Top level of the ray-circle intersection distance block.
//
// Usage:
//   Write the circle through the configuration port (i_cfg_we, i_cfg_idx,
//   i_cfg_data): center x, center y, radius, on-surface tolerance, at indexes
//   0 to 3, one per cycle, only while no request is in flight.
//   Each request on i_req carries a point and a direction; one result per
//   request leaves on o_rsp in request order: the distance to the nearest
//   forward crossing (all ones on a miss), a hit flag and an on-surface flag.
//   Throughput is one request per cycle while i_req.ready is high. The path
//   from the edge that accepts a request to its result on o_rsp runs through
//   the 63 square-root digit stages and 32 quotient stages.
//   Reset clears all valid bits and loads center 0, radius 0, tolerance 1.
//   The result register has a skid entry behind it: when the receiver
//   stalls, one more result is caught there, then i_req.ready drops and the
//   whole pipeline holds until the receiver takes a result.
module ray_circle_intersection_distance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rcid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    rcid_in_if.sink                          i_req,
    rcid_out_if.source                       o_rsp
);
    import rcid_pkg::*;

    t_cfg r_cfg;
    t_res w_core_res, r_out, r_skid;
    logic w_core_vld, w_en, w_push, w_pop;
    logic r_out_vld, r_skid_vld, n_out_vld, n_skid_vld;
    logic w_ld_core, w_ld_skid_out, w_ld_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x             <= '0;
            r_cfg.center_y             <= '0;
            r_cfg.radius               <= '0;
            r_cfg.on_surface_tolerance <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                CFG_RADIUS:   r_cfg.radius   <= i_cfg_data[30:0];
                CFG_ON_TOL:   r_cfg.on_surface_tolerance <= i_cfg_data[15:0];
            endcase
        end
    end

    assign w_en        = !r_skid_vld;
    assign i_req.ready = w_en;

    rcid_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_req.valid),
        .i_pos_x (i_req.pos_x),
        .i_pos_y (i_req.pos_y),
        .i_dir_x (i_req.dir_x),
        .i_dir_y (i_req.dir_y),
        .i_cfg   (r_cfg),
        .o_vld   (w_core_vld),
        .o_res   (w_core_res)
    );

    assign w_push = w_en && w_core_vld;
    assign w_pop  = r_out_vld && o_rsp.ready;

    always_comb begin
        n_out_vld     = r_out_vld;
        n_skid_vld    = r_skid_vld;
        w_ld_core     = 1'b0;
        w_ld_skid_out = 1'b0;
        w_ld_skid     = 1'b0;
        if (r_skid_vld) begin
            if (w_pop) begin
                w_ld_skid_out = 1'b1;
                n_skid_vld    = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_pop) begin
                w_ld_core = 1'b1;
                n_out_vld = 1'b1;
            end else begin
                w_ld_skid  = 1'b1;
                n_skid_vld = 1'b1;
            end
        end else if (w_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_core) begin
            r_out <= w_core_res;
        end else if (w_ld_skid_out) begin
            r_out <= r_skid;
        end
        if (w_ld_skid) begin
            r_skid <= w_core_res;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.distance   = r_out.distance;
    assign o_rsp.hit        = r_out.hit;
    assign o_rsp.on_surface = r_out.on_surface;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without a result in the output register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !o_rsp.ready) |=> r_skid_vld)
        else $error("skid entry dropped while the receiver stalls");

    a_miss_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.hit) |-> (o_rsp.distance == '1))
        else $error("miss reported with a distance other than all ones");

endmodule

### design/rcid_core.sv
// Pipelined datapath: products, discriminant, square root and division stages.
module rcid_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  rcid_pkg::t_cfg     i_cfg,
    output logic               o_vld,
    output rcid_pkg::t_res     o_res
);
    import rcid_pkg::*;

    logic [9:1] r_fv;

    logic signed [32:0] r1_x, r1_y;
    logic signed [31:0] r1_u, r1_v;

    logic [31:0] r2_mx, r2_my, r2_mu, r2_mv;
    logic        r2_sx, r2_sy, r2_su, r2_sv;

    logic [63:0] r3_xx, r3_yy, r3_uu, r3_vv, r3_xu, r3_yv, r3_xv, r3_yu;
    logic [61:0] r3_rr;
    logic        r3_nxu, r3_nyv, r3_nxv, r3_nyu;

    logic [63:0]        r4_a;
    logic [64:0]        r4_s2;
    logic [61:0]        r4_rr;
    logic signed [65:0] r4_txu, r4_tyv, r4_txv, r4_tyu;

    logic [63:0]        r5_a;
    logic [61:0]        r5_rr;
    logic signed [65:0] r5_h, r5_k;
    logic signed [66:0] r5_c;

    logic [61:0] r6_rr;
    logic [63:0] r6_km;
    t_ctx        r6_ctx;

    logic [63:0] r7_pll, r7_plh, r7_phl, r7_phh;
    logic [63:0] r7_qll, r7_qlh, r7_qhl, r7_qhh;
    t_ctx        r7_ctx;

    logic [64:0] r8_pmid, r8_qmid;
    logic [63:0] r8_pll, r8_phh, r8_qll, r8_qhh;
    t_ctx        r8_ctx;

    logic [127:0] r9_p, r9_q;
    t_ctx         r9_ctx;

    logic [65:0] w_txu, w_tyv, w_txv, w_tyu;
    logic [65:0] w_habs, w_kabs;
    logic signed [66:0] w_tol;
    logic [63:0] w_rr64;
    logic [128:0] w_diff;
    t_ctx         w_sq_ctx;

    logic [SQ_N:0]     r_sq_rem  [0:SQ_N];
    logic [SQ_N-1:0]   r_sq_root [0:SQ_N];
    logic [2*SQ_N-1:0] r_sq_d    [0:SQ_N];
    t_ctx              r_sq_ctx  [0:SQ_N];
    logic              r_sq_vld  [0:SQ_N];

    logic [63:0] w_s64, w_n;
    logic        w_nhit;
    logic [63:0] r_nn, r_na;
    logic        r_nhit, r_non, r_nvld;

    logic [65:0]     r_dv_rm  [0:DV_N];
    logic [DV_N-1:0] r_dv_q   [0:DV_N];
    logic [63:0]     r_dv_a   [0:DV_N];
    logic            r_dv_hit [0:DV_N];
    logic            r_dv_on  [0:DV_N];
    logic            r_dv_vld [0:DV_N];

    assign w_txu  = {2'b00, r3_xu};
    assign w_tyv  = {2'b00, r3_yv};
    assign w_txv  = {2'b00, r3_xv};
    assign w_tyu  = {2'b00, r3_yu};
    assign w_habs = r5_h[65] ? 66'(-r5_h) : r5_h;
    assign w_kabs = r5_k[65] ? 66'(-r5_k) : r5_k;
    assign w_tol  = $signed({51'b0, i_cfg.on_surface_tolerance});
    assign w_rr64 = {2'b00, r6_rr};
    assign w_diff = {1'b0, r9_p} - {1'b0, r9_q};

    always_comb begin
        w_sq_ctx       = r9_ctx;
        w_sq_ctx.dzero = (r9_p == r9_q);
        w_sq_ctx.dneg  = w_diff[128];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (i_en) begin
            r_fv <= {r_fv[8:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x <= $signed({i_pos_x[31], i_pos_x}) - $signed({i_cfg.center_x[31], i_cfg.center_x});
            r1_y <= $signed({i_pos_y[31], i_pos_y}) - $signed({i_cfg.center_y[31], i_cfg.center_y});
            r1_u <= i_dir_x;
            r1_v <= i_dir_y;

            r2_mx <= r1_x[32] ? 32'(-r1_x) : r1_x[31:0];
            r2_my <= r1_y[32] ? 32'(-r1_y) : r1_y[31:0];
            r2_mu <= r1_u[31] ? 32'(-{1'b1, r1_u}) : r1_u;
            r2_mv <= r1_v[31] ? 32'(-{1'b1, r1_v}) : r1_v;
            r2_sx <= r1_x[32];
            r2_sy <= r1_y[32];
            r2_su <= r1_u[31];
            r2_sv <= r1_v[31];

            r3_xx  <= r2_mx * r2_mx;
            r3_yy  <= r2_my * r2_my;
            r3_uu  <= r2_mu * r2_mu;
            r3_vv  <= r2_mv * r2_mv;
            r3_xu  <= r2_mx * r2_mu;
            r3_yv  <= r2_my * r2_mv;
            r3_xv  <= r2_mx * r2_mv;
            r3_yu  <= r2_my * r2_mu;
            r3_rr  <= i_cfg.radius * i_cfg.radius;
            r3_nxu <= r2_sx ^ r2_su;
            r3_nyv <= r2_sy ^ r2_sv;
            r3_nxv <= r2_sx ^ r2_sv;
            r3_nyu <= r2_sy ^ r2_su;

            r4_a   <= r3_uu + r3_vv;
            r4_s2  <= {1'b0, r3_xx} + {1'b0, r3_yy};
            r4_rr  <= r3_rr;
            r4_txu <= r3_nxu ? 66'(-w_txu) : w_txu;
            r4_tyv <= r3_nyv ? 66'(-w_tyv) : w_tyv;
            r4_txv <= r3_nxv ? 66'(-w_txv) : w_txv;
            r4_tyu <= r3_nyu ? 66'(-w_tyu) : w_tyu;

            r5_a  <= r4_a;
            r5_rr <= r4_rr;
            r5_h  <= r4_txu + r4_tyv;
            r5_k  <= r4_txv - r4_tyu;
            r5_c  <= $signed({2'b00, r4_s2}) - $signed({5'b0, r4_rr});

            r6_rr          <= r5_rr;
            r6_km          <= w_kabs[63:0];
            r6_ctx.a       <= r5_a;
            r6_ctx.hm      <= w_habs[63:0];
            r6_ctx.hneg    <= r5_h[65];
            r6_ctx.cneg    <= r5_c[66];
            r6_ctx.cpos    <= !r5_c[66] && (r5_c != '0);
            r6_ctx.dzero   <= 1'b0;
            r6_ctx.dneg    <= 1'b0;
            r6_ctx.on_surf <= (r5_c < w_tol) && (r5_c > -w_tol);

            r7_pll <= r6_ctx.a[31:0]  * w_rr64[31:0];
            r7_plh <= r6_ctx.a[31:0]  * w_rr64[63:32];
            r7_phl <= r6_ctx.a[63:32] * w_rr64[31:0];
            r7_phh <= r6_ctx.a[63:32] * w_rr64[63:32];
            r7_qll <= r6_km[31:0]  * r6_km[31:0];
            r7_qlh <= r6_km[31:0]  * r6_km[63:32];
            r7_qhl <= r6_km[63:32] * r6_km[31:0];
            r7_qhh <= r6_km[63:32] * r6_km[63:32];
            r7_ctx <= r6_ctx;

            r8_pmid <= {1'b0, r7_plh} + {1'b0, r7_phl};
            r8_qmid <= {1'b0, r7_qlh} + {1'b0, r7_qhl};
            r8_pll  <= r7_pll;
            r8_phh  <= r7_phh;
            r8_qll  <= r7_qll;
            r8_qhh  <= r7_qhh;
            r8_ctx  <= r7_ctx;

            r9_p   <= {r8_phh, r8_pll} + {31'b0, r8_pmid, 32'b0};
            r9_q   <= {r8_qhh, r8_qll} + {31'b0, r8_qmid, 32'b0};
            r9_ctx <= r8_ctx;

            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_d[0]    <= w_diff[2*SQ_N-1:0];
            r_sq_ctx[0]  <= w_sq_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_vld[0] <= r_fv[9];
        end
    end

    generate
        for (genvar j = 1; j <= SQ_N; j++) begin : g_sq
            logic [SQ_N+2:0] w_rem, w_trial, w_sub;
            logic            w_ge;

            assign w_rem   = {r_sq_rem[j-1], r_sq_d[j-1][2*SQ_N-1 -: 2]};
            assign w_trial = {1'b0, r_sq_root[j-1], 2'b01};
            assign w_ge    = (w_rem >= w_trial);
            assign w_sub   = w_rem - w_trial;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq_rem[j]  <= w_ge ? w_sub[SQ_N:0] : w_rem[SQ_N:0];
                    r_sq_root[j] <= {r_sq_root[j-1][SQ_N-2:0], w_ge};
                    r_sq_d[j]    <= {r_sq_d[j-1][2*SQ_N-3:0], 2'b00};
                    r_sq_ctx[j]  <= r_sq_ctx[j-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_sq_vld[j] <= r_sq_vld[j-1];
                end
            end
        end
    endgenerate

    always_comb begin
        w_s64  = {1'b0, r_sq_root[SQ_N]};
        w_n    = '0;
        w_nhit = 1'b0;
        if (r_sq_ctx[SQ_N].a != '0) begin
            if (r_sq_ctx[SQ_N].dzero) begin
                if (r_sq_ctx[SQ_N].hneg || (r_sq_ctx[SQ_N].hm == '0)) begin
                    w_n    = r_sq_ctx[SQ_N].hm;
                    w_nhit = 1'b1;
                end
            end else if (!r_sq_ctx[SQ_N].dneg) begin
                if (r_sq_ctx[SQ_N].cneg) begin
                    w_n    = r_sq_ctx[SQ_N].hneg ? (w_s64 + r_sq_ctx[SQ_N].hm)
                                                 : (w_s64 - r_sq_ctx[SQ_N].hm);
                    w_nhit = 1'b1;
                end else if (r_sq_ctx[SQ_N].hneg) begin
                    w_n    = r_sq_ctx[SQ_N].cpos ? (r_sq_ctx[SQ_N].hm - w_s64)
                                                 : (r_sq_ctx[SQ_N].hm + w_s64);
                    w_nhit = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nn   <= w_n;
            r_nhit <= w_nhit;
            r_na   <= r_sq_ctx[SQ_N].a;
            r_non  <= r_sq_ctx[SQ_N].on_surf;

            r_dv_rm[0]  <= {2'b00, r_nn};
            r_dv_q[0]   <= '0;
            r_dv_a[0]   <= r_na;
            r_dv_hit[0] <= r_nhit && ({2'b00, r_nn} < {r_na, 2'b00});
            r_dv_on[0]  <= r_non;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld      <= 1'b0;
            r_dv_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_nvld      <= r_sq_vld[SQ_N];
            r_dv_vld[0] <= r_nvld;
        end
    end

    generate
        for (genvar k = 1; k <= DV_N; k++) begin : g_dv
            localparam int BI = DV_N - k;
            logic [65:0] w_sh, w_dv, w_df;
            logic        w_ge;

            assign w_sh = (BI >= DIR_FRAC) ? r_dv_rm[k-1] : {r_dv_rm[k-1][64:0], 1'b0};
            assign w_dv = (BI == DV_N - 1) ? {1'b0, r_dv_a[k-1], 1'b0}
                                           : {2'b00, r_dv_a[k-1]};
            assign w_ge = (w_sh >= w_dv);
            assign w_df = w_sh - w_dv;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv_rm[k]  <= w_ge ? w_df : w_sh;
                    r_dv_q[k]   <= {r_dv_q[k-1][DV_N-2:0], w_ge};
                    r_dv_a[k]   <= r_dv_a[k-1];
                    r_dv_hit[k] <= r_dv_hit[k-1];
                    r_dv_on[k]  <= r_dv_on[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_dv_vld[k] <= r_dv_vld[k-1];
                end
            end
        end
    endgenerate

    assign o_vld            = r_dv_vld[DV_N];
    assign o_res.distance   = r_dv_hit[DV_N] ? r_dv_q[DV_N] : '1;
    assign o_res.hit        = r_dv_hit[DV_N];
    assign o_res.on_surface = r_dv_on[DV_N];

endmodule

### test/rcid_checker.sv
// Checker for the ray-circle intersection distance block: predicts and compares results.
`timescale 1ns / 1ps
module rcid_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [rcid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_dir_x,
    input  logic [31:0] i_dir_y,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_distance,
    input  logic        i_hit,
    input  logic        i_on_surface,
    output int          o_errors,
    output int          o_pending,
    output int          o_hits,
    output int          o_results
);
    import rcid_pkg::*;

    t_cfg cfg;
    t_res expected_q[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, o_results);
        o_errors++;
    endtask

    function automatic logic [255:0] isqrt(input logic [255:0] d);
        logic [255:0] s;
        logic [255:0] c;
        s = 0;
        for (int b = 63; b >= 0; b--) begin
            c = s | (256'd1 << b);
            if (c * c <= d) s = c;
        end
        return s;
    endfunction

    function automatic t_res crossing(input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] dx, input logic [31:0] dy);
        logic signed [255:0] x, y, u, v, r, a, h, c, k, disc, n, num;
        logic [255:0] quo;
        t_res res;
        logic hit;
        x = $signed(px) - $signed(cfg.center_x);
        y = $signed(py) - $signed(cfg.center_y);
        u = $signed(dx);
        v = $signed(dy);
        r = {225'd0, cfg.radius};
        a = u * u + v * v;
        h = x * u + y * v;
        c = x * x + y * y - r * r;
        k = x * v - y * u;
        disc = a * r * r - k * k;
        hit = 0;
        n = 0;
        if (a != 0) begin
            if (disc == 0) begin
                if (h <= 0) begin
                    n = -h;
                    hit = 1;
                end
            end else if (disc > 0) begin
                if (c < 0) begin
                    n = $signed(isqrt(disc)) - h;
                    hit = 1;
                end else if (h < 0) begin
                    n = (c > 0) ? -h - $signed(isqrt(disc)) : -h + $signed(isqrt(disc));
                    hit = 1;
                end
            end
        end
        res.distance = 32'hFFFF_FFFF;
        if (hit) begin
            num = n <<< 30;
            quo = num / a;
            if (quo >= 256'h1_0000_0000) hit = 0;
            else res.distance = quo[31:0];
        end
        res.hit = hit;
        if (c < 0) c = -c;
        res.on_surface = (c < $signed({240'd0, cfg.on_surface_tolerance}));
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            cfg <= '{center_x: 0, center_y: 0, radius: 0, on_surface_tolerance: 1};
            expected_q.delete();
            o_errors = 0;
            o_hits <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_X: cfg.center_x <= i_cfg_data;
                    CFG_CENTER_Y: cfg.center_y <= i_cfg_data;
                    CFG_RADIUS:   cfg.radius <= i_cfg_data[30:0];
                    CFG_ON_TOL:   cfg.on_surface_tolerance <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                expected_q.push_back(crossing(i_pos_x, i_pos_y, i_dir_x, i_dir_y));
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_q.size() == 0) begin
                    $display("unexpected result: distance %h", i_distance);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_distance !== want.distance) report("distance", i_distance, want.distance);
                    if (i_hit !== want.hit) report("hit", i_hit, want.hit);
                    if (i_on_surface !== want.on_surface)
                        report("on_surface", i_on_surface, want.on_surface);
                    if (want.hit) o_hits <= o_hits + 1;
                end
                o_results <= o_results + 1;
            end
        end
    end
endmodule

### test/testbench.sv
// Top of the ray-circle intersection distance testbench: clock, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import rcid_pkg::*;

    localparam int LATENCY = 107;
    localparam int WATCHDOG = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_CENTER_X;
    logic [31:0] i_cfg_data = 0;
    int errors, pending, hits, results;
    int idle_cycles = 0;
    int items_sent = 0;
    bit hold_long = 0;
    bit done = 0;

    rcid_in_if req_if();
    rcid_out_if rsp_if();

    ray_circle_intersection_distance uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_if.sink), .o_rsp(rsp_if.source)
    );

    rcid_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req_valid(req_if.valid), .i_req_ready(req_if.ready),
        .i_pos_x(req_if.pos_x), .i_pos_y(req_if.pos_y), .i_dir_x(req_if.dir_x),
        .i_dir_y(req_if.dir_y), .i_rsp_valid(rsp_if.valid), .i_rsp_ready(rsp_if.ready),
        .i_distance(rsp_if.distance), .i_hit(rsp_if.hit), .i_on_surface(rsp_if.on_surface),
        .o_errors(errors), .o_pending(pending), .o_hits(hits), .o_results(results)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_if.valid = 0;
        req_if.pos_x = 0;
        req_if.pos_y = 0;
        req_if.dir_x = 0;
        req_if.dir_y = 0;
        rsp_if.ready = 0;
    end

    // receiver: random stalls, with one long hold-off
    initial begin
        int gap;
        repeat (10) @(posedge i_clk);
        forever begin
            if (hold_long) begin
                rsp_if.ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_long = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                rsp_if.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || done)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("[ray_circle_intersection_distance] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] r, input logic [31:0] tol);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_ON_TOL, tol);
        i_cfg_we <= 0;
    endtask

    task automatic send(input logic [31:0] px, input logic [31:0] py,
                        input logic [31:0] dx, input logic [31:0] dy, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9));
        if (gap > 0) begin
            req_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1;
        req_if.pos_x <= px;
        req_if.pos_y <= py;
        req_if.dir_x <= dx;
        req_if.dir_y <= dy;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain;
        req_if.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick(input logic [31:0] center, input logic [31:0] r);
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return center + $signed($urandom_range(0, 2 * r[30:0] + 2)) - $signed(r[30:0]);
            2: return center + r;
            3: return center - r;
            default: return center;
        endcase
    endfunction

    function automatic logic [31:0] pick_dir;
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return 32'h4000_0000;
            2: return 32'hC000_0000;
            3: return 0;
            4: return 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] cx, cy, r, tol;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: defaults, then a unit circle
        send(0, 0, 32'h4000_0000, 0, 1);
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        drain();
        set_circle(0, 0, 32'h0001_0000, 1);
        send(32'hFFFE_0000, 0, 32'h4000_0000, 0, 0);       // outside, two roots
        send(0, 0, 32'h4000_0000, 0, 0);                   // inside
        send(32'h0001_0000, 0, 32'hC000_0000, 0, 0);       // on circle, inward
        send(32'h0001_0000, 0, 32'h4000_0000, 0, 0);       // on circle, outward
        send(32'hFFFE_0000, 32'h0001_0000, 32'h4000_0000, 0, 0); // tangent
        send(0, 32'h0001_0000, 32'h4000_0000, 0, 0);       // tangent at zero distance
        send(32'h0002_0000, 0, 32'h4000_0000, 0, 0);       // moving away
        send(0, 32'h0005_0000, 32'h4000_0000, 0, 0);       // miss
        send(0, 0, 0, 0, 0);                               // zero direction
        send(32'h8000_0000, 0, 32'h0000_0001, 0, 0);       // overflow
        send(32'hFFFF_0000, 0, 32'h8000_0000, 32'h8000_0000, 0);
        send(32'h0000_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        drain();
        set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send(32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000, 32'hC000_0000, 0);
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 0, 0);
        send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        drain();
        set_circle(0, 0, 32'h0001_0000, 16'hFFFF);
        send(32'h0001_0000, 0, 32'h4000_0000, 0, 0);
        send(32'h0001_0001, 0, 32'h4000_0000, 0, 0);
        // long receiver hold-off while requests keep coming
        hold_long = 1;
        for (int i = 0; i < 200; i++) send(pick(0, 32'h0001_0000), pick(0, 32'h0001_0000),
                                          pick_dir(), pick_dir(), 1);
        drain();
        // random phases with varied circles
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: r = $urandom_range(0, 32'h0010_0000);
                1: r = $urandom() >> 1;
                2: r = $urandom_range(0, 16);
                default: r = $urandom_range(0, 32'h7FFF);
            endcase
            cx = (p % 3 == 0) ? $urandom() : $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            cy = (p % 3 == 0) ? $urandom() : $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            tol = (p == 5) ? 0 : (p == 6) ? 16'hFFFF : $urandom_range(0, 16'hFFFF);
            set_circle(cx, cy, r, tol);
            for (int i = 0; i < 120; i++) send(pick(cx, r), pick(cy, r), pick_dir(), pick_dir(), 0);
            drain();
        end
        done = 1;
        $display("sent %0d requests, %0d results checked, %0d with a hit", items_sent, results, hits);
        $display("covered tangent, inside, outside, on-circle, zero-direction and overflow cases");
        if (errors == 0) begin
            $display("[ray_circle_intersection_distance] OK");
        end else begin
            $display("[ray_circle_intersection_distance] ERROR");
        end
        $finish;
    end
endmodule

### sim.f
design/rcid_pkg.sv
design/rcid_in_if.sv
design/rcid_out_if.sv
design/rcid_core.sv
design/ray_circle_intersection_distance.sv
test/rcid_checker.sv
test/testbench.sv
